// ===== design/tkt_pkg.sv =====
package tkt_pkg;

	localparam int TABLE_ENTRIES_DEF = 8;
	localparam int KEY_BYTES_DEF     = 16;
	// Index width for the largest supported table (64 entries)
	localparam int IDX_W_MAX         = 6;

	localparam logic [31:0] TTL_RESET = 32'd3600000;

	localparam logic [1:0] FUNC_CREATE   = 2'd0;
	localparam logic [1:0] FUNC_VALIDATE = 2'd1;
	localparam logic [1:0] FUNC_DESTROY  = 2'd2;

	localparam logic [1:0] REG_TTL_ADDR  = 2'd0;

	typedef logic [IDX_W_MAX-1:0] idx_t;

	typedef struct packed {
		logic        age;
		logic        write;
		logic [1:0]  op;
		idx_t        idx;
		logic [63:0] key_high;
		logic [63:0] key_low;
		logic [46:0] now;
		logic [47:0] expiry;
	} tkt_cmd_t;

	typedef struct packed {
		logic        free_found;
		idx_t        free_idx;
		logic        match_found;
		idx_t        match_idx;
		logic        min_found;
		idx_t        min_idx;
		logic [47:0] min_exp;
	} tkt_scan_t;

endpackage

// ===== design/tkt_if.sv =====
interface tkt_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  func;
	logic [63:0] key_high;
	logic [63:0] key_low;
	logic [46:0] now_ms;

	modport source (output valid, func, key_high, key_low, now_ms, input ready);
	modport sink (input valid, func, key_high, key_low, now_ms, output ready);
endinterface

interface tkt_rsp_if;
	logic       valid;
	logic       ready;
	logic       status;
	logic [2:0] slot;
	logic       evicted;

	modport source (output valid, status, slot, evicted, input ready);
	modport sink (input valid, status, slot, evicted, output ready);
endinterface

// ===== design/tkt_cell.sv =====
module tkt_cell #(
	parameter int INDEX = 0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  tkt_pkg::tkt_cmd_t   cmd,
	input  tkt_pkg::tkt_scan_t  scan_in,
	output tkt_pkg::tkt_scan_t  scan_out
);
	import tkt_pkg::*;

	logic        valid_q;
	logic [63:0] key_high_q;
	logic [63:0] key_low_q;
	logic [47:0] expiry_q;
	tkt_scan_t   scan_d;
	tkt_scan_t   scan_q;
	logic        sel;
	logic        hit;
	idx_t        own_idx;

	assign own_idx = IDX_W_MAX'(INDEX);
	assign sel = cmd.write && (cmd.idx == own_idx);
	assign hit = valid_q && (key_high_q == cmd.key_high) && (key_low_q == cmd.key_low);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.age && valid_q && ({1'b0, cmd.now} >= expiry_q)) begin
			valid_q <= 1'b0;
		end else if (sel) begin
			case (cmd.op)
				FUNC_CREATE:  valid_q <= 1'b1;
				FUNC_DESTROY: valid_q <= 1'b0;
				default:      valid_q <= valid_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (sel && cmd.op == FUNC_CREATE) begin
			key_high_q <= cmd.key_high;
			key_low_q  <= cmd.key_low;
		end
		if (sel && (cmd.op == FUNC_CREATE || cmd.op == FUNC_VALIDATE)) begin
			expiry_q <= cmd.expiry;
		end
	end

	// Fold this entry into the scan word and hand it on
	always_comb begin
		scan_d = scan_in;
		if (!scan_in.free_found && !valid_q) begin
			scan_d.free_found = 1'b1;
			scan_d.free_idx   = own_idx;
		end
		if (!scan_in.match_found && hit) begin
			scan_d.match_found = 1'b1;
			scan_d.match_idx   = own_idx;
		end
		if (!scan_in.min_found || expiry_q < scan_in.min_exp) begin
			scan_d.min_found = 1'b1;
			scan_d.min_idx   = own_idx;
			scan_d.min_exp   = expiry_q;
		end
	end

	always_ff @(posedge clk) begin
		scan_q <= scan_d;
	end

	assign scan_out = scan_q;

endmodule

// ===== design/timed_key_table_with_eviction.sv =====
// Keyed entry table with expiry times and eviction of the entry with the earliest expiry.
// req channel (valid/ready): func, key_high, key_low, now_ms. One request is
// taken at a time; req.ready is high only while the table is idle.
// rsp channel (valid/ready): status, slot, evicted; exactly one word per
// request. The response sits in an output register until taken, and the
// next request is accepted while it waits there.
// Processing: after acceptance the request passes an ageing state, a scan
// state in which the scan word walks down the chain of entry cells and is
// registered in each cell, an update state and an output load. The table
// takes no new request until it has finished the last one and is idle
// again. A stalled receiver holds the finished result in the table until
// the output register frees.
// Configuration: APB register ttl_ms at byte address 0 is to be written only while
// idle; the block itself does not enforce this. A read returns its value.
// Reset: all entries invalid, ttl_ms back to 3600000, no response pending.
module timed_key_table_with_eviction #(
	parameter int TABLE_ENTRIES = tkt_pkg::TABLE_ENTRIES_DEF,
	parameter int KEY_BYTES     = tkt_pkg::KEY_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	tkt_req_if.sink     req,
	tkt_rsp_if.source   rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import tkt_pkg::*;

	localparam int IDX_W     = $clog2(TABLE_ENTRIES);
	localparam int HIGH_BITS = (KEY_BYTES - 8) * 8;
	localparam logic [63:0] KEY_HIGH_MASK = 64'((65'd1 << HIGH_BITS) - 65'd1);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_AGE   = 3'd1;
	localparam logic [2:0] ST_SCAN  = 3'd2;
	localparam logic [2:0] ST_APPLY = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	logic [2:0]       state_q;
	logic [IDX_W-1:0] cnt_q;
	logic [31:0]      ttl_q;

	logic [1:0]  func_q;
	logic [63:0] key_high_q;
	logic [63:0] key_low_q;
	logic [46:0] now_q;
	logic [47:0] expiry_q;

	logic        res_status_q;
	idx_t        res_idx_q;
	logic        res_evicted_q;

	logic        rsp_valid_q;
	logic        rsp_status_q;
	logic [2:0]  rsp_slot_q;
	logic        rsp_evicted_q;

	tkt_cmd_t    cmd;
	tkt_scan_t   scan [TABLE_ENTRIES+1];
	tkt_scan_t   fin;
	logic        pick_write;
	idx_t        pick_idx;
	logic        pick_status;
	logic        pick_evicted;
	logic        accept;
	logic        out_free;

	assign pready = 1'b1;
	assign prdata = (paddr == REG_TTL_ADDR) ? ttl_q : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ttl_q <= TTL_RESET;
		end else if (psel && penable && pwrite && paddr == REG_TTL_ADDR) begin
			ttl_q <= pwdata;
		end
	end

	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign out_free  = !rsp_valid_q || rsp.ready;

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q     <= req.func;
			key_high_q <= req.key_high & KEY_HIGH_MASK;
			key_low_q  <= req.key_low;
			now_q      <= req.now_ms;
			expiry_q   <= {1'b0, req.now_ms} + {16'd0, ttl_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_AGE;
					end
				end
				ST_AGE: begin
					state_q <= ST_SCAN;
					cnt_q   <= IDX_W'(TABLE_ENTRIES - 1);
				end
				ST_SCAN: begin
					if (cnt_q == '0) begin
						state_q <= ST_APPLY;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				ST_APPLY: state_q <= ST_DONE;
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign fin = scan[TABLE_ENTRIES];

	always_comb begin
		pick_write   = 1'b0;
		pick_idx     = '0;
		pick_status  = 1'b1;
		pick_evicted = 1'b0;
		case (func_q)
			FUNC_CREATE: begin
				pick_write  = 1'b1;
				pick_status = 1'b0;
				if (fin.free_found) begin
					pick_idx = fin.free_idx;
				end else begin
					pick_idx     = fin.min_idx;
					pick_evicted = 1'b1;
				end
			end
			FUNC_VALIDATE, FUNC_DESTROY: begin
				if (fin.match_found) begin
					pick_write  = 1'b1;
					pick_status = 1'b0;
					pick_idx    = fin.match_idx;
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		cmd.age      = (state_q == ST_AGE) &&
		               (func_q == FUNC_CREATE || func_q == FUNC_VALIDATE);
		cmd.write    = (state_q == ST_APPLY) && pick_write;
		cmd.op       = func_q;
		cmd.idx      = pick_idx;
		cmd.key_high = key_high_q;
		cmd.key_low  = key_low_q;
		cmd.now      = now_q;
		cmd.expiry   = expiry_q;
	end

	assign scan[0] = '0;

	for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
		tkt_cell #(
			.INDEX(i)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.cmd     (cmd),
			.scan_in (scan[i]),
			.scan_out(scan[i+1])
		);
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_APPLY) begin
			res_status_q  <= pick_status;
			res_idx_q     <= pick_idx;
			res_evicted_q <= pick_evicted;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			rsp_status_q  <= res_status_q;
			rsp_slot_q    <= res_idx_q[2:0];
			rsp_evicted_q <= res_evicted_q;
		end
	end

	assign rsp.valid   = rsp_valid_q;
	assign rsp.status  = rsp_status_q;
	assign rsp.slot    = rsp_slot_q;
	assign rsp.evicted = rsp_evicted_q;

endmodule

// ===== tb/tb.sv =====
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import tkt_pkg::*;

	localparam int ENTRIES = TABLE_ENTRIES_DEF;
	localparam int KEY_BITS = KEY_BYTES_DEF * 8;
	localparam logic [127:0] KEY_MASK = (KEY_BITS >= 128) ? '1 : ((128'd1 << KEY_BITS) - 128'd1);
	localparam logic [1:0] FUNC_UNUSED = 2'd3;
	localparam logic [63:0] ONES = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] KB_H = 64'h8000_0000_0000_0001;
	localparam logic [63:0] KB_L = 64'h0123_4567_89AB_CDEF;
	localparam logic [63:0] KC_H = 64'hAAAA_AAAA_AAAA_AAAA;
	localparam logic [63:0] KC_L = 64'h5555_5555_5555_5555;
	localparam logic [46:0] TIME_MAX = 47'h7FFF_FFFF_FFFF;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int LONG_HOLD = 300;
	localparam int PHASES = 8;
	localparam int ITEMS_PER_PHASE = 140;
	localparam int KEY_POOL = 12;
	localparam int DIRECTED_ROWS = 25;
	localparam int TAIL_CYCLES = 40;

	typedef struct packed {
		logic       status;
		logic [2:0] slot;
		logic       evicted;
	} reply_t;

	typedef struct packed {
		logic        cfg;
		logic [1:0]  func;
		logic [63:0] key_high;
		logic [63:0] key_low;
		logic [46:0] now_ms;
		logic        typed;
		reply_t      want;
	} stim_row_t;

	localparam reply_t MISS = '{1'b1, 3'd0, 1'b0};

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [1:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	tkt_req_if req ();
	tkt_rsp_if rsp ();

	timed_key_table_with_eviction u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rsp     (rsp),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	logic         ent_valid [ENTRIES];
	logic [127:0] ent_key [ENTRIES];
	logic [47:0]  ent_expiry [ENTRIES];
	logic [31:0]  ttl_model;

	reply_t pending_replies[$];
	reply_t got_reply;
	reply_t want_reply;

	stim_row_t   directed_rows [DIRECTED_ROWS];
	logic [63:0] pool_high [KEY_POOL];
	logic [63:0] pool_low [KEY_POOL];
	logic [31:0] phase_ttl [PHASES];
	int unsigned phase_step [PHASES];
	int          gap_pct [4];
	int          stall_pct [4];

	int gap_now;
	int stall_now;
	bit hold_pending;
	int n_errors;
	int n_sent;
	int n_directed;
	int n_replies;
	int n_evictions;
	int n_hits;
	int n_ttl_writes;
	int n_holds;
	int idle_cycles;

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	function automatic void note_failure(string msg);
		n_errors++;
		if (n_errors <= 10)
			$display("%s", msg);
	endfunction

	function automatic void clear_entry(int idx);
		ent_valid[idx] = 1'b0;
		ent_key[idx] = '0;
		ent_expiry[idx] = '0;
	endfunction

	function automatic void expire_entries(logic [46:0] now);
		for (int i = 0; i < ENTRIES; i++)
			if (ent_valid[i] && {1'b0, now} >= ent_expiry[i])
				clear_entry(i);
	endfunction

	function automatic int lookup_key(logic [127:0] key);
		for (int i = 0; i < ENTRIES; i++)
			if (ent_valid[i] && ent_key[i] == key)
				return i;
		return -1;
	endfunction

	function automatic reply_t apply_request(logic [1:0] func, logic [127:0] key_in,
			logic [46:0] now);
		reply_t r;
		logic [127:0] key;
		logic [47:0] fresh;
		int pick;
		r = MISS;
		key = key_in & KEY_MASK;
		fresh = {1'b0, now} + {16'd0, ttl_model};
		pick = -1;
		case (func)
			FUNC_CREATE: begin
				expire_entries(now);
				for (int i = 0; i < ENTRIES; i++)
					if (!ent_valid[i] && pick < 0)
						pick = i;
				if (pick < 0) begin
					pick = 0;
					for (int i = 1; i < ENTRIES; i++)
						if (ent_expiry[i] < ent_expiry[pick])
							pick = i;
					r.evicted = 1'b1;
				end
				ent_valid[pick] = 1'b1;
				ent_key[pick] = key;
				ent_expiry[pick] = fresh;
				r.status = 1'b0;
				r.slot = 3'(pick);
			end
			FUNC_VALIDATE: begin
				expire_entries(now);
				pick = lookup_key(key);
				if (pick >= 0) begin
					ent_expiry[pick] = fresh;
					r.status = 1'b0;
					r.slot = 3'(pick);
				end
			end
			FUNC_DESTROY: begin
				pick = lookup_key(key);
				if (pick >= 0) begin
					clear_entry(pick);
					r.status = 1'b0;
					r.slot = 3'(pick);
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic send_request(logic [1:0] func, logic [63:0] kh, logic [63:0] kl,
			logic [46:0] now, bit typed, reply_t want);
		reply_t r;
		while ($urandom_range(99) < gap_now) begin
			req.valid <= 1'b0;
			@(negedge clk);
		end
		req.valid <= 1'b1;
		req.func <= func;
		req.key_high <= kh;
		req.key_low <= kl;
		req.now_ms <= now;
		do @(posedge clk); while (!req.ready);
		r = apply_request(func, {kh, kl}, now);
		pending_replies.push_back(typed ? want : r);
		n_sent++;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		req.valid <= 1'b0;
		while (pending_replies.size() != 0)
			@(negedge clk);
	endtask

	task automatic program_ttl(logic [31:0] value);
		wait_drained();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= REG_TTL_ADDR;
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		ttl_model = value;
		n_ttl_writes++;
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== value)
			note_failure($sformatf("ttl read back: expected %0d, got %0d", value, prdata));
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// check each word taken from the response channel against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && rsp.valid && rsp.ready) begin
			n_replies++;
			got_reply = '{rsp.status, rsp.slot, rsp.evicted};
			if (got_reply.evicted === 1'b1)
				n_evictions++;
			if (got_reply.status === 1'b0)
				n_hits++;
			if (pending_replies.size() == 0) begin
				note_failure($sformatf("unexpected word: status %0b slot %0d evicted %0b",
					got_reply.status, got_reply.slot, got_reply.evicted));
			end else begin
				want_reply = pending_replies.pop_front();
				if (got_reply.status !== want_reply.status || got_reply.slot !== want_reply.slot
						|| got_reply.evicted !== want_reply.evicted)
					note_failure($sformatf({"word %0d: expected status %0b slot %0d evicted %0b,",
						" got status %0b slot %0d evicted %0b"}, n_replies,
						want_reply.status, want_reply.slot, want_reply.evicted,
						got_reply.status, got_reply.slot, got_reply.evicted));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		rsp.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_pending) begin
				hold_pending = 1'b0;
				n_holds++;
				repeat (LONG_HOLD) begin
					rsp.ready <= 1'b0;
					@(negedge clk);
				end
			end
			rsp.ready <= ($urandom_range(99) >= stall_now);
		end
	end

	initial begin
		logic [46:0] now_cur;
		logic [1:0]  func;
		logic [63:0] kh;
		logic [63:0] kl;
		int          k;
		int          pick;
		int          mode;
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.func = FUNC_CREATE;
		req.key_high = '0;
		req.key_low = '0;
		req.now_ms = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		gap_now = 0;
		stall_now = 0;
		hold_pending = 1'b0;
		n_errors = 0;
		n_sent = 0;
		n_replies = 0;
		n_evictions = 0;
		n_hits = 0;
		n_ttl_writes = 0;
		n_holds = 0;
		idle_cycles = 0;
		ttl_model = TTL_RESET;
		for (int i = 0; i < ENTRIES; i++)
			clear_entry(i);

		directed_rows = '{
			'{1'b0, FUNC_VALIDATE, 64'd0, 64'd0, 47'd0, 1'b1, MISS},
			'{1'b0, FUNC_DESTROY, 64'd0, 64'd0, 47'd0, 1'b1, MISS},
			'{1'b0, FUNC_UNUSED, ONES, ONES, 47'd0, 1'b1, MISS},
			'{1'b0, FUNC_CREATE, ONES, ONES, 47'd0, 1'b1, '{1'b0, 3'd0, 1'b0}},
			'{1'b0, FUNC_CREATE, 64'd0, 64'd0, 47'd1, 1'b1, '{1'b0, 3'd1, 1'b0}},
			'{1'b0, FUNC_VALIDATE, ONES, ONES, 47'd2, 1'b1, '{1'b0, 3'd0, 1'b0}},
			'{1'b0, FUNC_CREATE, 64'd0, 64'd2, 47'd3, 1'b1, '{1'b0, 3'd2, 1'b0}},
			'{1'b0, FUNC_CREATE, 64'd0, 64'd3, 47'd4, 1'b1, '{1'b0, 3'd3, 1'b0}},
			'{1'b0, FUNC_CREATE, 64'd0, 64'd4, 47'd5, 1'b1, '{1'b0, 3'd4, 1'b0}},
			'{1'b0, FUNC_CREATE, 64'd0, 64'd5, 47'd6, 1'b1, '{1'b0, 3'd5, 1'b0}},
			'{1'b0, FUNC_CREATE, 64'd0, 64'd6, 47'd7, 1'b1, '{1'b0, 3'd6, 1'b0}},
			'{1'b0, FUNC_CREATE, 64'd0, 64'd7, 47'd8, 1'b1, '{1'b0, 3'd7, 1'b0}},
			'{1'b0, FUNC_CREATE, 64'd0, 64'd8, 47'd9, 1'b0, '0},
			'{1'b0, FUNC_DESTROY, ONES, ONES, 47'd10, 1'b1, '{1'b0, 3'd0, 1'b0}},
			'{1'b0, FUNC_DESTROY, ONES, ONES, 47'd11, 1'b1, MISS},
			'{1'b0, FUNC_CREATE, 64'd0, 64'd9, 47'd12, 1'b1, '{1'b0, 3'd0, 1'b0}},
			'{1'b1, FUNC_CREATE, 64'd0, 64'd0, 47'd0, 1'b0, '0},
			'{1'b0, FUNC_CREATE, KB_H, KB_L, 47'd20, 1'b0, '0},
			'{1'b0, FUNC_VALIDATE, KB_H, KB_L, 47'd20, 1'b1, MISS},
			'{1'b1, FUNC_CREATE, 64'd0, 64'hFFFF_FFFF, 47'd0, 1'b0, '0},
			'{1'b0, FUNC_CREATE, KB_H, KB_L, TIME_MAX, 1'b1, '{1'b0, 3'd0, 1'b0}},
			'{1'b0, FUNC_VALIDATE, KB_H, KB_L, 47'd5, 1'b1, '{1'b0, 3'd0, 1'b0}},
			'{1'b0, FUNC_DESTROY, KB_H, KB_L, 47'd6, 1'b1, '{1'b0, 3'd0, 1'b0}},
			'{1'b1, FUNC_CREATE, 64'd0, 64'd1, 47'd0, 1'b0, '0},
			'{1'b0, FUNC_VALIDATE, KC_H, KC_L, 47'd7, 1'b1, MISS}
		};
		phase_ttl = '{32'd100, 32'd1, 32'hFFFF_FFFF, 32'd0, 32'd5000, 32'd0, TTL_RESET, 32'd20};
		phase_step = '{30, 2, 1000, 1, 2000, 100, 1000000, 8};
		gap_pct = '{0, 50, 0, 16};
		stall_pct = '{0, 0, 50, 16};
		for (int i = 0; i < KEY_POOL; i++) begin
			pool_high[i] = {$urandom, $urandom};
			pool_low[i] = {$urandom, $urandom};
		end

		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].cfg)
				program_ttl(directed_rows[i].key_low[31:0]);
			else
				send_request(directed_rows[i].func, directed_rows[i].key_high,
					directed_rows[i].key_low, directed_rows[i].now_ms,
					directed_rows[i].typed, directed_rows[i].want);
		end
		n_directed = n_sent;

		now_cur = '0;
		for (int p = 0; p < PHASES; p++) begin
			program_ttl(p == 5 ? 32'($urandom_range(300, 1)) : phase_ttl[p]);
			mode = p % 4;
			gap_now = gap_pct[mode];
			stall_now = stall_pct[mode];
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (p == 2 && n == 10)
					hold_pending = 1'b1;
				if (p == 4 && n == 70)
					wait_drained();
				pick = $urandom_range(99);
				if (pick < 40)
					func = FUNC_CREATE;
				else if (pick < 75)
					func = FUNC_VALIDATE;
				else if (pick < 95)
					func = FUNC_DESTROY;
				else
					func = FUNC_UNUSED;
				if ($urandom_range(9) == 0) begin
					kh = {$urandom, $urandom};
					kl = {$urandom, $urandom};
				end else begin
					k = $urandom_range(KEY_POOL - 1);
					kh = pool_high[k];
					kl = pool_low[k];
				end
				pick = $urandom_range(99);
				if (pick < 2)
					now_cur = 47'({$urandom, $urandom});
				else if (pick < 5)
					now_cur = now_cur - 47'($urandom_range(phase_step[p]));
				else
					now_cur = now_cur + 47'($urandom_range(phase_step[p]));
				send_request(func, kh, kl, now_cur, 1'b0, '0);
			end
		end

		wait_drained();
		repeat (TAIL_CYCLES) @(negedge clk);

		$display("Sent %0d requests (%0d directed) under %0d ttl settings, %0d long stalls.",
			n_sent, n_directed, n_ttl_writes, n_holds);
		$display("Took %0d words: %0d successes, %0d evictions.", n_replies, n_hits, n_evictions);
		if (n_errors == 0 && pending_replies.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
